FILE: rtl/core/gcap_pkg.sv
`default_nettype none
package gcap_pkg;

  localparam int HdrBytes   = 6;
  localparam int EntBytes   = 4;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] ExpectedTypeRst = 8'd11;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DESC   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PARTIAL   = 2'd1;
  localparam logic [1:0] ST_WRONG     = 2'd2;
  localparam logic [1:0] ST_TOO_SHORT = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ENTRY,
    PH_DATA,
    PH_TRAILER,
    PH_REJECT
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] frame_addr;
    logic [7:0] info_byte;
    logic       no_byte;
    logic       end_of_frame;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] addr_out;
    logic [7:0] val_a;
    logic [7:0] val_b;
    logic [7:0] val_c;
    logic [7:0] val_d;
    logic [7:0] val_e;
    logic [1:0] status;
    logic [7:0] entries_done;
    logic       last;
  } res_t;

  // up to two results per transaction; second slot only used with the first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_pair_t;

endpackage
`default_nettype wire

FILE: rtl/core/gcap_in_stage.sv
`default_nettype none
module gcap_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire gcap_pkg::item_t in_item,
  output logic                s_valid,
  output gcap_pkg::item_t     s_item,
  input  wire logic           s_take
);

  assign in_ready = !s_valid || s_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/gcap_parse.sv
`default_nettype none
module gcap_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  input  wire logic              fire,
  input  wire gcap_pkg::item_t   item,
  output gcap_pkg::res_pair_t    res
);

  gcap_pkg::phase_t phase, phase_next;
  gcap_pkg::phase_t phase_in, phase_mid;
  logic [7:0]  expected_type;
  logic [2:0]  byte_pos, byte_pos_next;
  logic [2:0]  pos_in;
  logic        type_ok, type_ok_next;
  logic [7:0]  inf, inf_next, rii, rii_next, grp, grp_next;
  logic [7:0]  ent, ent_next, ngd, ngd_next;
  logic [7:0]  kod, kod_next, dtype, dtype_next, dsize, dsize_next, dnum, dnum_next;
  logic [15:0] gid_remaining, gid_remaining_next;
  logic [7:0]  entry_index, entry_index_next;
  logic [7:0]  idx_in;
  logic [7:0]  entries_complete, entries_complete_next;
  logic        partial_flag, partial_flag_next;
  logic        partial_mid;
  logic [7:0]  frame_addr_reg, frame_addr_reg_next;

  always_comb begin
    logic           fin;
    logic [15:0]    prod;

    phase_next            = phase;
    byte_pos_next         = byte_pos;
    type_ok_next          = type_ok;
    inf_next              = inf;
    rii_next              = rii;
    grp_next              = grp;
    ent_next              = ent;
    ngd_next              = ngd;
    kod_next              = kod;
    dtype_next            = dtype;
    dsize_next            = dsize;
    dnum_next             = dnum;
    gid_remaining_next    = gid_remaining;
    entry_index_next      = entry_index;
    entries_complete_next = entries_complete;
    partial_flag_next     = partial_flag;
    frame_addr_reg_next   = frame_addr_reg;
    fin                   = 1'b0;
    prod                  = 16'(dsize_next) * 16'(dnum_next);

    if (phase == gcap_pkg::PH_IDLE) begin
      type_ok_next          = (item.frame_type == expected_type);
      frame_addr_reg_next   = item.frame_addr;
      byte_pos_next         = '0;
      entry_index_next      = '0;
      entries_complete_next = '0;
      partial_flag_next     = 1'b0;
      gid_remaining_next    = '0;
      phase_next = type_ok_next ? gcap_pkg::PH_HEADER : gcap_pkg::PH_REJECT;
    end

    phase_in = phase_next;
    pos_in   = byte_pos_next;
    idx_in   = entry_index_next;

    if (!item.no_byte) begin
      unique case (phase_in)
        gcap_pkg::PH_HEADER: begin
          unique case (pos_in)
            3'd1:    inf_next = item.info_byte;
            3'd2:    rii_next = item.info_byte;
            3'd3:    grp_next = item.info_byte;
            3'd4:    ent_next = item.info_byte;
            3'd5:    ngd_next = item.info_byte;
            default: ;
          endcase
          if (pos_in == 3'(gcap_pkg::HdrBytes - 1)) begin
            byte_pos_next  = '0;
            phase_next = (ngd_next == 8'd0) ? gcap_pkg::PH_TRAILER : gcap_pkg::PH_ENTRY;
          end else begin
            byte_pos_next = byte_pos_next + 3'd1;
          end
        end
        gcap_pkg::PH_ENTRY: begin
          unique case (pos_in)
            3'd0:    kod_next   = item.info_byte;
            3'd1:    dtype_next = item.info_byte;
            3'd2:    dsize_next = item.info_byte;
            3'd3:    dnum_next  = item.info_byte;
            default: ;
          endcase
          partial_flag_next = 1'b1;
          prod = 16'(dsize_next) * 16'(dnum_next);
          if (pos_in == 3'(gcap_pkg::EntBytes - 1)) begin
            gid_remaining_next = prod;
            byte_pos_next      = '0;
            if (prod == 16'd0) begin
              fin = 1'b1;
            end else begin
              phase_next = gcap_pkg::PH_DATA;
            end
          end else begin
            byte_pos_next = byte_pos_next + 3'd1;
          end
        end
        gcap_pkg::PH_DATA: begin
          gid_remaining_next = gid_remaining_next - 16'd1;
          fin                = (gid_remaining_next == 16'd0);
        end
        default: ;
      endcase
    end

    if (fin) begin
      entries_complete_next = entries_complete_next + 8'd1;
      entry_index_next      = entry_index_next + 8'd1;
      partial_flag_next     = 1'b0;
      byte_pos_next         = '0;
      phase_next = (entry_index_next >= ngd_next) ? gcap_pkg::PH_TRAILER
                                                  : gcap_pkg::PH_ENTRY;
    end

    phase_mid   = phase_next;
    partial_mid = partial_flag_next;

    if (item.end_of_frame) begin
      phase_next        = gcap_pkg::PH_IDLE;
      byte_pos_next     = '0;
      partial_flag_next = 1'b0;
    end
  end

  always_comb begin
    gcap_pkg::res_t byte_res;
    gcap_pkg::res_t end_res;
    logic           byte_v;

    byte_res = '0;
    end_res  = '0;
    byte_v   = 1'b0;

    if (!item.no_byte) begin
      unique case (phase_in)
        gcap_pkg::PH_HEADER: begin
          if (pos_in == 3'(gcap_pkg::HdrBytes - 1)) begin
            byte_v         = 1'b1;
            byte_res.kind  = gcap_pkg::KIND_HEADER;
            byte_res.val_a = inf_next;
            byte_res.val_b = rii_next;
            byte_res.val_c = grp_next;
            byte_res.val_d = ent_next;
            byte_res.val_e = ngd_next;
          end
        end
        gcap_pkg::PH_ENTRY: begin
          if (pos_in == 3'(gcap_pkg::EntBytes - 1)) begin
            byte_v         = 1'b1;
            byte_res.kind  = gcap_pkg::KIND_DESC;
            byte_res.val_a = kod_next;
            byte_res.val_b = dtype_next;
            byte_res.val_c = dsize_next;
            byte_res.val_d = dnum_next;
            byte_res.val_e = idx_in;
          end
        end
        gcap_pkg::PH_DATA: begin
          byte_v         = 1'b1;
          byte_res.kind  = gcap_pkg::KIND_DATA;
          byte_res.val_a = item.info_byte;
          byte_res.val_b = idx_in;
        end
        default: ;
      endcase
    end

    end_res.kind = gcap_pkg::KIND_END;
    if (!type_ok_next) begin
      end_res.status = gcap_pkg::ST_WRONG;
    end else if (phase_mid == gcap_pkg::PH_HEADER) begin
      end_res.status = gcap_pkg::ST_TOO_SHORT;
    end else begin
      end_res.status       = partial_mid ? gcap_pkg::ST_PARTIAL : gcap_pkg::ST_OK;
      end_res.entries_done = entries_complete_next;
    end
    end_res.last = 1'b1;

    byte_res.addr_out = frame_addr_reg_next;
    end_res.addr_out  = frame_addr_reg_next;
    byte_res.last     = !item.end_of_frame;

    res.v0 = fire && (byte_v || item.end_of_frame);
    res.v1 = fire && byte_v && item.end_of_frame;
    res.r0 = byte_v ? byte_res : end_res;
    res.r1 = end_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type    <= gcap_pkg::ExpectedTypeRst;
      phase            <= gcap_pkg::PH_IDLE;
      byte_pos         <= '0;
      type_ok          <= 1'b0;
      inf              <= '0;
      rii              <= '0;
      grp              <= '0;
      ent              <= '0;
      ngd              <= '0;
      kod              <= '0;
      dtype            <= '0;
      dsize            <= '0;
      dnum             <= '0;
      gid_remaining    <= '0;
      entry_index      <= '0;
      entries_complete <= '0;
      partial_flag     <= 1'b0;
      frame_addr_reg   <= '0;
    end else begin
      if (cfg_wr_en) begin
        expected_type <= cfg_wr_data;
      end
      if (fire) begin
        phase            <= phase_next;
        byte_pos         <= byte_pos_next;
        type_ok          <= type_ok_next;
        inf              <= inf_next;
        rii              <= rii_next;
        grp              <= grp_next;
        ent              <= ent_next;
        ngd              <= ngd_next;
        kod              <= kod_next;
        dtype            <= dtype_next;
        dsize            <= dsize_next;
        dnum             <= dnum_next;
        gid_remaining    <= gid_remaining_next;
        entry_index      <= entry_index_next;
        entries_complete <= entries_complete_next;
        partial_flag     <= partial_flag_next;
        frame_addr_reg   <= frame_addr_reg_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    res.v1 |-> res.v0)
    else $error("second result without first");
  a_second_is_end: assert property (@(posedge clk) disable iff (rst)
    res.v1 |-> (res.r1.kind == gcap_pkg::KIND_END && !res.r0.last))
    else $error("second result is not the frame end status");
  a_data_needs_count: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == gcap_pkg::PH_DATA) |-> (gid_remaining != 16'd0))
    else $error("data phase with no bytes left");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/gcap_out_queue.sv
`default_nettype none
module gcap_out_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gcap_pkg::res_pair_t push,
  output logic                     room2,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gcap_pkg::res_t           out_res
);

  gcap_pkg::res_t entries [gcap_pkg::QueueDepth];
  logic [gcap_pkg::QPtrW-1:0] wr_ptr, wr_ptr_next, rd_ptr;
  logic [gcap_pkg::QCntW-1:0] count, count_next;
  logic                       pop;

  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= gcap_pkg::QCntW'(gcap_pkg::QueueDepth - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + gcap_pkg::QPtrW'(push.v0) + gcap_pkg::QPtrW'(push.v1);
    count_next  = count + gcap_pkg::QCntW'(push.v0) + gcap_pkg::QCntW'(push.v1)
                  - gcap_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + gcap_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      entries[wr_ptr + gcap_pkg::QPtrW'(1)] <= push.r1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= gcap_pkg::QCntW'(gcap_pkg::QueueDepth))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> room2)
    else $error("push without room for two results");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/generic_catalog_asdu_parser_core.sv
`default_nettype none
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    frame_type frame_addr info_byte no_byte end_of_frame
// out       output     out_valid/out_ready  kind addr_out val_a..val_e status entries_done last
// cfg       input      cfg_wr_en            cfg_wr_data (expected_type)
//
// One transaction per cycle on in while in_ready is high; it is registered in the input stage
// and parsed from there in one pass. Each transaction yields 0, 1 or 2 results into a 4-deep
// queue; out drains one per cycle while out_ready is high. in stalls while the queue holds
// more than two results and the input stage is full. The first result reaches out through the
// input stage register and the queue register. rst is synchronous; expected_type resets to 11.
module generic_catalog_asdu_parser_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] frame_type,
  input  wire logic [7:0] frame_addr,
  input  wire logic [7:0] info_byte,
  input  wire logic       no_byte,
  input  wire logic       end_of_frame,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      addr_out,
  output logic [7:0]      val_a,
  output logic [7:0]      val_b,
  output logic [7:0]      val_c,
  output logic [7:0]      val_d,
  output logic [7:0]      val_e,
  output logic [1:0]      status,
  output logic [7:0]      entries_done,
  output logic            last
);

  gcap_pkg::item_t     in_item, s_item;
  gcap_pkg::res_pair_t pair;
  gcap_pkg::res_t      out_res;
  logic                s_valid, room2, fire;

  assign in_item.frame_type   = frame_type;
  assign in_item.frame_addr   = frame_addr;
  assign in_item.info_byte    = info_byte;
  assign in_item.no_byte      = no_byte;
  assign in_item.end_of_frame = end_of_frame;

  assign fire = s_valid && room2;

  gcap_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_item   (s_item),
    .s_take   (fire)
  );

  gcap_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (s_item),
    .res         (pair)
  );

  gcap_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pair),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind         = out_res.kind;
  assign addr_out     = out_res.addr_out;
  assign val_a        = out_res.val_a;
  assign val_b        = out_res.val_b;
  assign val_c        = out_res.val_c;
  assign val_d        = out_res.val_d;
  assign val_e        = out_res.val_e;
  assign status       = out_res.status;
  assign entries_done = out_res.entries_done;
  assign last         = out_res.last;

endmodule
`default_nettype wire

FILE: verif/tb_generic_catalog_asdu_parser_core.sv
`timescale 1ns / 1ps
module tb_generic_catalog_asdu_parser_core;

  localparam int ItemsPerPhase = 350;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] frame_type = '0;
  logic [7:0] frame_addr = '0;
  logic [7:0] info_byte = '0;
  logic       no_byte = 1'b0;
  logic       end_of_frame = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] addr_out;
  logic [7:0] val_a;
  logic [7:0] val_b;
  logic [7:0] val_c;
  logic [7:0] val_d;
  logic [7:0] val_e;
  logic [1:0] status;
  logic [7:0] entries_done;
  logic       last;

  generic_catalog_asdu_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_type   (frame_type),
    .frame_addr   (frame_addr),
    .info_byte    (info_byte),
    .no_byte      (no_byte),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .addr_out     (addr_out),
    .val_a        (val_a),
    .val_b        (val_b),
    .val_c        (val_c),
    .val_d        (val_d),
    .val_e        (val_e),
    .status       (status),
    .entries_done (entries_done),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // parser shadow state
  logic [7:0]        cfg_type = gcap_pkg::ExpectedTypeRst;
  gcap_pkg::phase_t  sh_phase = gcap_pkg::PH_IDLE;
  logic [2:0]        sh_pos = '0;
  logic              sh_type_ok = 1'b0;
  logic [7:0]        sh_hdr [5] = '{default: '0};
  logic [7:0]        sh_ent [4] = '{default: '0};
  logic [15:0]       sh_left = '0;
  logic [7:0]        sh_idx = '0;
  logic [7:0]        sh_done = '0;
  logic              sh_partial = 1'b0;
  logic [7:0]        sh_addr = '0;

  gcap_pkg::res_t due_records[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   send_idle_pct = 38;
  int   recv_idle_pct = 75;

  typedef struct {
    gcap_pkg::item_t it;
    logic            typed;
    logic [1:0]      st;
  } row_t;

  row_t dir_rows[$];

  function automatic gcap_pkg::res_t catalog_rec(input logic [1:0] k,
                                                 input logic [7:0] a, b, c, d, e);
    gcap_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.addr_out = sh_addr;
    r.val_a = a;
    r.val_b = b;
    r.val_c = c;
    r.val_d = d;
    r.val_e = e;
    return r;
  endfunction

  function automatic void close_entry();
    sh_done = sh_done + 8'd1;
    sh_idx = sh_idx + 8'd1;
    sh_partial = 1'b0;
    sh_pos = '0;
    sh_phase = (sh_idx >= sh_hdr[4]) ? gcap_pkg::PH_TRAILER : gcap_pkg::PH_ENTRY;
  endfunction

  function automatic void track_catalog(input gcap_pkg::item_t it);
    gcap_pkg::res_t recs[$];
    gcap_pkg::res_t r;
    if (sh_phase == gcap_pkg::PH_IDLE) begin
      sh_type_ok = (it.frame_type == cfg_type);
      sh_addr = it.frame_addr;
      sh_pos = '0;
      sh_idx = '0;
      sh_done = '0;
      sh_partial = 1'b0;
      sh_left = '0;
      sh_phase = sh_type_ok ? gcap_pkg::PH_HEADER : gcap_pkg::PH_REJECT;
    end
    if (!it.no_byte) begin
      case (sh_phase)
        gcap_pkg::PH_HEADER: begin
          if (sh_pos != 3'd0) sh_hdr[sh_pos - 3'd1] = it.info_byte;
          sh_pos = sh_pos + 3'd1;
          if (sh_pos == 3'(gcap_pkg::HdrBytes)) begin
            recs.push_back(catalog_rec(gcap_pkg::KIND_HEADER, sh_hdr[0], sh_hdr[1],
                                       sh_hdr[2], sh_hdr[3], sh_hdr[4]));
            sh_pos = '0;
            sh_phase = (sh_hdr[4] == 8'd0) ? gcap_pkg::PH_TRAILER : gcap_pkg::PH_ENTRY;
          end
        end
        gcap_pkg::PH_ENTRY: begin
          sh_ent[sh_pos[1:0]] = it.info_byte;
          sh_partial = 1'b1;
          sh_pos = sh_pos + 3'd1;
          if (sh_pos == 3'(gcap_pkg::EntBytes)) begin
            recs.push_back(catalog_rec(gcap_pkg::KIND_DESC, sh_ent[0], sh_ent[1],
                                       sh_ent[2], sh_ent[3], sh_idx));
            sh_left = 16'(sh_ent[2]) * 16'(sh_ent[3]);
            if (sh_left == 16'd0) begin
              close_entry();
            end else begin
              sh_pos = '0;
              sh_phase = gcap_pkg::PH_DATA;
            end
          end
        end
        gcap_pkg::PH_DATA: begin
          recs.push_back(catalog_rec(gcap_pkg::KIND_DATA, it.info_byte, sh_idx,
                                     '0, '0, '0));
          sh_left = sh_left - 16'd1;
          if (sh_left == 16'd0) close_entry();
        end
        default: ;
      endcase
    end
    if (it.end_of_frame) begin
      r = catalog_rec(gcap_pkg::KIND_END, '0, '0, '0, '0, '0);
      if (!sh_type_ok) begin
        r.status = gcap_pkg::ST_WRONG;
      end else if (sh_phase == gcap_pkg::PH_HEADER) begin
        r.status = gcap_pkg::ST_TOO_SHORT;
      end else begin
        r.status = sh_partial ? gcap_pkg::ST_PARTIAL : gcap_pkg::ST_OK;
        r.entries_done = sh_done;
      end
      recs.push_back(r);
      sh_phase = gcap_pkg::PH_IDLE;
      sh_pos = '0;
      sh_partial = 1'b0;
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) due_records.push_back(recs[i]);
  endfunction

  function automatic string rec_str(input gcap_pkg::res_t r);
    return $sformatf({"kind=%0d addr=%02h a=%02h b=%02h c=%02h d=%02h e=%02h",
                      " st=%0d done=%0d last=%0b"},
                     r.kind, r.addr_out, r.val_a, r.val_b, r.val_c, r.val_d, r.val_e,
                     r.status, r.entries_done, r.last);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic gcap_pkg::item_t make_item(input bit fresh, input logic [7:0] ft, fa, ib,
                                                input logic nb, eof);
    gcap_pkg::item_t it;
    it.frame_type = fresh ? ft : 8'($urandom);
    it.frame_addr = fresh ? fa : 8'($urandom);
    it.info_byte = ib;
    it.no_byte = nb;
    it.end_of_frame = eof;
    return it;
  endfunction

  function automatic void add_row(input logic [7:0] ft, fa, ib, input logic nb, eof,
                                  input logic typed = 1'b0,
                                  input logic [1:0] st = gcap_pkg::ST_OK);
    row_t row;
    row.it = make_item(1'b1, ft, fa, ib, nb, eof);
    row.typed = typed;
    row.st = st;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input gcap_pkg::item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_type <= it.frame_type;
    frame_addr <= it.frame_addr;
    info_byte <= it.info_byte;
    no_byte <= it.no_byte;
    end_of_frame <= it.end_of_frame;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic apply_item(input gcap_pkg::item_t it);
    send_item(it);
    track_catalog(it);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_type = v;
  endtask

  task automatic random_frame();
    logic [7:0] bytes[$];
    logic [7:0] ngd;
    logic [7:0] sz;
    logic [7:0] num;
    logic [7:0] ft;
    logic [7:0] fa;
    int n_ent;
    int cut;
    bit tail_eof;
    bit fresh;
    ft = ($urandom_range(0, 99) < 8) ? 8'($urandom) : cfg_type;
    fa = 8'($urandom);
    fresh = 1'b1;
    repeat (5) bytes.push_back(8'($urandom));
    ngd = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    bytes.push_back(ngd);
    n_ent = (ngd > 8'd4) ? int'($urandom_range(0, 4)) : int'(ngd);
    repeat (n_ent) begin
      case ($urandom_range(0, 29))
        0: begin
          sz = 8'hFF;
          num = 8'd1;
        end
        1: begin
          sz = 8'd0;
          num = 8'hFF;
        end
        2: begin
          sz = 8'($urandom);
          num = 8'd0;
        end
        default: begin
          sz = 8'($urandom_range(0, 3));
          num = 8'($urandom_range(0, 3));
        end
      endcase
      bytes.push_back(8'($urandom));
      bytes.push_back(8'($urandom));
      bytes.push_back(sz);
      bytes.push_back(num);
      repeat (int'(sz) * int'(num)) bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, bytes.size());
      while (bytes.size() > cut) void'(bytes.pop_back());
    end
    tail_eof = (bytes.size() == 0) || ($urandom_range(0, 1) == 1);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) begin
        apply_item(make_item(fresh, ft, fa, 8'($urandom), 1'b1, 1'b0));
        fresh = 1'b0;
      end
      apply_item(make_item(fresh, ft, fa, bytes[i], 1'b0, !tail_eof && i == bytes.size() - 1));
      fresh = 1'b0;
    end
    if (tail_eof) apply_item(make_item(fresh, ft, fa, 8'($urandom), 1'b1, 1'b1));
  endtask

  always @(posedge clk) begin
    gcap_pkg::res_t got;
    gcap_pkg::res_t want;
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) begin
      got = {kind, addr_out, val_a, val_b, val_c, val_d, val_e, status, entries_done, last};
      if (due_records.size() == 0) begin
        note_mismatch($sformatf("unexpected result %s", rec_str(got)));
      end else begin
        want = due_records.pop_front();
        if (got !== want)
          note_mismatch($sformatf("exp %s\n    got %s", rec_str(want), rec_str(got)));
      end
    end
  end

  initial begin
    gcap_pkg::res_t r;
    // empty frame: too short
    add_row(gcap_pkg::ExpectedTypeRst, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, gcap_pkg::ST_TOO_SHORT);
    // wrong type wins over too short
    add_row(8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1, gcap_pkg::ST_WRONG);
    // NGD 3: empty entry, one-byte entry, then frame ends inside the third
    add_row(gcap_pkg::ExpectedTypeRst, 8'hA5, 8'h5A, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
    add_row(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'h80, 1'b0, 1'b0);
    add_row(8'h00, 8'hFF, 8'h7F, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'h03, 1'b0, 1'b0);
    add_row(8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    add_row(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
    add_row(8'h00, 8'hFF, 8'h01, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'h03, 1'b0, 1'b0);
    add_row(8'h00, 8'hFF, 8'h01, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'h01, 1'b0, 1'b0);
    add_row(8'h00, 8'hFF, 8'hAA, 1'b0, 1'b0);
    add_row(8'hFF, 8'h00, 8'h55, 1'b0, 1'b1);
    // NGD 0 followed by a trailing byte
    add_row(gcap_pkg::ExpectedTypeRst, 8'h3C, 8'h00, 1'b0, 1'b0);
    add_row(8'h00, 8'h00, 8'h12, 1'b0, 1'b0);
    add_row(8'h00, 8'h00, 8'h34, 1'b0, 1'b0);
    add_row(8'h00, 8'h00, 8'h56, 1'b0, 1'b0);
    add_row(8'h00, 8'h00, 8'h78, 1'b0, 1'b0);
    add_row(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    add_row(8'h00, 8'h00, 8'hC3, 1'b0, 1'b1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it);
      if (dir_rows[i].typed) begin
        // single-item frames: shadow state is back at idle either way
        r = '0;
        r.kind = gcap_pkg::KIND_END;
        r.addr_out = dir_rows[i].it.frame_addr;
        r.status = dir_rows[i].st;
        r.last = 1'b1;
        due_records.push_back(r);
      end else begin
        track_catalog(dir_rows[i].it);
      end
    end

    settle();
    write_cfg(8'h00);
    items_sent = 0;
    while (items_sent < ItemsPerPhase) random_frame();

    settle();
    write_cfg(8'hFF);
    send_idle_pct = 75;
    recv_idle_pct = 38;
    items_sent = 0;
    while (items_sent < ItemsPerPhase) random_frame();

    settle();
    write_cfg(8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    while (items_sent < ItemsPerPhase) random_frame();

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
